// ===== rtl/core/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// mte_pkg: shared types and constants of the Morse text encoder
// Symbol codes, sequencer states, controller/datapath command and status
// structures and the character-to-Morse code table.
// ----------------------------------------------------------------------------
package mte_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned SymWidth  = 2;
   localparam int unsigned PatWidth  = 5;
   localparam int unsigned LenWidth  = 3;
   localparam int unsigned TdataWidth = 8;

   localparam logic [SymWidth-1:0] SYM_DOT  = 2'd0;
   localparam logic [SymWidth-1:0] SYM_DASH = 2'd1;
   localparam logic [SymWidth-1:0] SYM_LGAP = 2'd2;
   localparam logic [SymWidth-1:0] SYM_WGAP = 2'd3;

   localparam logic [CharWidth-1:0] CHR_SPACE = 8'h20;
   localparam logic [CharWidth-1:0] CHR_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CHR_NINE  = 8'h39;
   localparam logic [CharWidth-1:0] CHR_UA    = 8'h41;
   localparam logic [CharWidth-1:0] CHR_UZ    = 8'h5a;
   localparam logic [CharWidth-1:0] CHR_LA    = 8'h61;
   localparam logic [CharWidth-1:0] CHR_LZ    = 8'h7a;
   localparam logic [CharWidth-1:0] CASE_OFFSET = 8'h20;
   localparam logic [5:0]           DIGIT_BASE  = 6'd26;

   typedef enum logic [1:0] {
      GAP_NONE   = 2'd0,
      GAP_LETTER = 2'd1,
      GAP_WORD   = 2'd2
   } gap_type;

   typedef enum logic [1:0] {
      CH_LETTER,
      CH_SPACE,
      CH_OTHER
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PEND,
      ST_ELEM,
      ST_BAD,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_GAP,
      EMIT_ELEM,
      EMIT_BAD
   } emit_type;

   typedef enum logic [1:0] {
      GAP_OP_HOLD,
      GAP_OP_LETTER,
      GAP_OP_WORD,
      GAP_OP_CLEAR
   } gap_op_type;

   typedef struct packed {
      logic       load;
      emit_type   emit;
      logic       last;
      logic       cnt_clr;
      logic       cnt_inc;
      gap_op_type gap_op;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     gap_pending;
      logic     eom;
      logic     elem_last;
      logic     slot_free;
   } status_type;

   typedef struct packed {
      logic [LenWidth-1:0] len;
      logic [PatWidth-1:0] pat;
   } code_type;

   // pat bit k is element k, 1 = dash
   function automatic code_type code_of(input logic [5:0] idx);
      logic [LenWidth+PatWidth-1:0] v;
      begin
         unique case (idx)
            6'd0:  v = {3'd2, 5'b00010};
            6'd1:  v = {3'd4, 5'b00001};
            6'd2:  v = {3'd4, 5'b00101};
            6'd3:  v = {3'd3, 5'b00001};
            6'd4:  v = {3'd1, 5'b00000};
            6'd5:  v = {3'd4, 5'b00100};
            6'd6:  v = {3'd3, 5'b00011};
            6'd7:  v = {3'd4, 5'b00000};
            6'd8:  v = {3'd2, 5'b00000};
            6'd9:  v = {3'd4, 5'b01110};
            6'd10: v = {3'd3, 5'b00101};
            6'd11: v = {3'd4, 5'b00010};
            6'd12: v = {3'd2, 5'b00011};
            6'd13: v = {3'd2, 5'b00001};
            6'd14: v = {3'd3, 5'b00111};
            6'd15: v = {3'd4, 5'b00110};
            6'd16: v = {3'd4, 5'b01011};
            6'd17: v = {3'd3, 5'b00010};
            6'd18: v = {3'd3, 5'b00000};
            6'd19: v = {3'd1, 5'b00001};
            6'd20: v = {3'd3, 5'b00100};
            6'd21: v = {3'd4, 5'b01000};
            6'd22: v = {3'd3, 5'b00110};
            6'd23: v = {3'd4, 5'b01001};
            6'd24: v = {3'd4, 5'b01101};
            6'd25: v = {3'd4, 5'b00011};
            6'd26: v = {3'd5, 5'b11111};
            6'd27: v = {3'd5, 5'b11110};
            6'd28: v = {3'd5, 5'b11100};
            6'd29: v = {3'd5, 5'b11000};
            6'd30: v = {3'd5, 5'b10000};
            6'd31: v = {3'd5, 5'b00000};
            6'd32: v = {3'd5, 5'b00001};
            6'd33: v = {3'd5, 5'b00011};
            6'd34: v = {3'd5, 5'b00111};
            6'd35: v = {3'd5, 5'b01111};
            default: v = '0;
         endcase
         code_of = code_type'(v);
      end
   endfunction

endpackage

// ===== rtl/core/mte_ctrl.sv =====
// ----------------------------------------------------------------------------
// mte_ctrl: encoder sequencer
// Walks one character through pending gap, elements, error and flush,
// issuing one result command per cycle when the output slot is free.
// ----------------------------------------------------------------------------
module mte_ctrl
   import mte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.kind)
               CH_LETTER: state_in = sts.gap_pending ? ST_PEND : ST_ELEM;
               CH_SPACE:  state_in = sts.eom ? ST_FLUSH : ST_IDLE;
               default:   state_in = ST_BAD;
            endcase
         end
         ST_PEND: begin
            if (sts.slot_free) begin
               state_in = ST_ELEM;
            end
         end
         ST_ELEM: begin
            if (sts.slot_free && sts.elem_last) begin
               state_in = sts.eom ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_BAD: begin
            if (sts.slot_free) begin
               state_in = (sts.eom && sts.gap_pending) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (sts.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.emit   = EMIT_NONE;
      cmd.gap_op = GAP_OP_HOLD;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         ST_DISPATCH: begin
            cmd.cnt_clr = 1'b1;
            if (sts.kind == CH_SPACE) begin
               cmd.gap_op = GAP_OP_WORD;
            end
         end
         ST_PEND: begin
            if (sts.slot_free) begin
               cmd.emit = EMIT_GAP;
            end
         end
         ST_ELEM: begin
            if (sts.slot_free) begin
               cmd.emit    = EMIT_ELEM;
               cmd.cnt_inc = 1'b1;
               if (sts.elem_last) begin
                  cmd.last   = !sts.eom;
                  cmd.gap_op = GAP_OP_LETTER;
               end
            end
         end
         ST_BAD: begin
            if (sts.slot_free) begin
               cmd.emit = EMIT_BAD;
               cmd.last = !(sts.eom && sts.gap_pending);
            end
         end
         ST_FLUSH: begin
            if (sts.slot_free) begin
               cmd.emit   = EMIT_GAP;
               cmd.last   = 1'b1;
               cmd.gap_op = GAP_OP_CLEAR;
            end
         end
         default: begin
            cmd.emit = EMIT_NONE;
         end
      endcase
   end

endmodule

// ===== rtl/core/mte_dpath.sv =====
// ----------------------------------------------------------------------------
// mte_dpath: encoder datapath
// Character decode and code lookup, pending gap, element counter and the
// result output register.
// ----------------------------------------------------------------------------
module mte_dpath
   import mte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CharWidth-1:0]  req_ch,
   input  logic                  req_eom,
   input  cmd_type               cmd,
   output status_type            sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SymWidth-1:0]   rsp_symbol,
   output logic                  rsp_bad,
   output logic                  rsp_last
);

   logic [CharWidth-1:0] up_ch;
   logic [CharWidth-1:0] off;
   logic [5:0]           idx;
   kind_type             kind_dec;
   code_type             code_dec;

   kind_type            kind_ff;
   logic [PatWidth-1:0] pat_ff;
   logic [LenWidth-1:0] len_ff;
   logic                eom_ff;
   gap_type             gap_ff;
   gap_type             gap_in;
   logic [LenWidth-1:0] cnt_ff;
   logic [LenWidth-1:0] cnt_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [SymWidth-1:0] sym_ff;
   logic [SymWidth-1:0] sym_in;
   logic                bad_ff;
   logic                last_ff;
   logic [SymWidth-1:0] gap_sym;

   always_comb begin
      up_ch = req_ch;
      if (req_ch >= CHR_LA && req_ch <= CHR_LZ) begin
         up_ch = req_ch - CASE_OFFSET;
      end
      off      = '0;
      kind_dec = CH_OTHER;
      idx      = '0;
      if (up_ch >= CHR_UA && up_ch <= CHR_UZ) begin
         kind_dec = CH_LETTER;
         off      = up_ch - CHR_UA;
         idx      = off[5:0];
      end else if (up_ch >= CHR_ZERO && up_ch <= CHR_NINE) begin
         kind_dec = CH_LETTER;
         off      = up_ch - CHR_ZERO;
         idx      = DIGIT_BASE + off[5:0];
      end else if (up_ch == CHR_SPACE) begin
         kind_dec = CH_SPACE;
      end
      code_dec = code_of(idx);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_dec;
         pat_ff  <= code_dec.pat;
         len_ff  <= code_dec.len;
         eom_ff  <= req_eom;
      end
   end

   always_comb begin
      unique case (cmd.gap_op)
         GAP_OP_LETTER: gap_in = GAP_LETTER;
         GAP_OP_WORD:   gap_in = GAP_WORD;
         GAP_OP_CLEAR:  gap_in = GAP_NONE;
         default:       gap_in = gap_ff;
      endcase
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_NONE;
         cnt_ff <= '0;
      end else begin
         gap_ff <= gap_in;
         cnt_ff <= cnt_in;
      end
   end

   assign gap_sym = (gap_ff == GAP_LETTER) ? SYM_LGAP : SYM_WGAP;

   always_comb begin
      unique case (cmd.emit)
         EMIT_GAP:  sym_in = gap_sym;
         EMIT_ELEM: sym_in = pat_ff[cnt_ff] ? SYM_DASH : SYM_DOT;
         default:   sym_in = SYM_DOT;
      endcase
      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         sym_ff  <= sym_in;
         bad_ff  <= (cmd.emit == EMIT_BAD);
         last_ff <= cmd.last;
      end
   end

   assign sts.kind        = kind_ff;
   assign sts.gap_pending = (gap_ff != GAP_NONE);
   assign sts.eom         = eom_ff;
   assign sts.elem_last   = ((cnt_ff + 3'd1) == len_ff);
   assign sts.slot_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_symbol = sym_ff;
   assign rsp_bad    = bad_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== rtl/core/morse_text_encoder.sv =====
// ----------------------------------------------------------------------------
// morse_text_encoder: ASCII character to Morse symbol stream
// One character in per req transfer (req_tlast ends the message); dots,
// dashes, letter gaps, word gaps and error flags out per rsp transfer.
// Letters fold to upper case; a letter gap is held and sent ahead of the
// next letter or on message end; spaces collapse into one word gap.
// Unknown characters give one result with rsp_tuser set.
// rsp_tlast marks the final result caused by a character; a space inside a
// message gives no result at all.
// Timing: the character is decoded as it is taken and registered; the
// sequencer dispatches it, then issues one result per cycle while the
// output slot is free, 0..7 results in all, before the next is taken.
// The first result enters the output register after the dispatch state.
// A stalled rsp side freezes the sequencer behind the single output
// register; req_tready stays low until the character is finished.
// Reset: synchronous; clears the pending gap, the sequencer and rsp_tvalid.
// ----------------------------------------------------------------------------
module morse_text_encoder
   import mte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CharWidth-1:0]  req_tdata,   // [7:0] ch
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TdataWidth-1:0] rsp_tdata,   // [1:0] symbol, [7:2] zero
   output logic [0:0]            rsp_tuser,   // [0] bad_char
   output logic                  rsp_tlast
);

   cmd_type             cmd;
   status_type          sts;
   logic [SymWidth-1:0] symbol;
   logic                bad;

   mte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mte_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_tdata),
      .req_eom    (req_tlast),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_symbol (symbol),
      .rsp_bad    (bad),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(TdataWidth-SymWidth){1'b0}}, symbol};
   assign rsp_tuser = bad;

   a_emit_needs_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.emit != EMIT_NONE |-> sts.slot_free)
      else $error("result issued while output register occupied");

   a_gap_emit_pending : assert property (@(posedge clock) disable iff (reset)
      cmd.emit == EMIT_GAP |-> sts.gap_pending)
      else $error("gap issued with nothing pending");

   a_bad_symbol_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[1:0] == SYM_DOT)
      else $error("error result with non-zero symbol");

   a_load_when_ready : assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> req_tready && req_tvalid)
      else $error("character loaded outside a req transfer");

endmodule
